FILE: rtl/thp_pkg.sv
`default_nettype none
package thp_pkg;

    // field widths
    localparam int DIM_W     = 16;  // orig_width, orig_height, canvas width, x coordinates
    localparam int CFG_W     = 12;  // tile height, tile gap
    localparam int QUOT_W    = 28;  // scaled width, product orig_width * tile height
    localparam int COL_W     = 17;  // column position incl. trailing gap
    localparam int Y_W       = 30;  // y coordinates, canvas height
    localparam int ROWS_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 168;

    localparam logic [Y_W-1:0]    Y_MAX    = '1;
    localparam logic [ROWS_W-1:0] ROWS_MAX = '1;

    // register reset values
    localparam logic [CFG_W-1:0] TILE_HEIGHT_RST  = 12'd28;
    localparam logic [CFG_W-1:0] TILE_GAP_RST     = 12'd4;
    localparam logic [DIM_W-1:0] CANVAS_WIDTH_RST = 16'd732;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        STAT_PLACED      = 2'd0,
        STAT_TOO_WIDE    = 2'd1,
        STAT_ZERO_HEIGHT = 2'd2,
        STAT_EARLIER_ERR = 2'd3
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/thumbnail_row_placer.sv
`default_nettype none
// Words are worked one at a time through a 28-step restoring divider.
// Zero-height words skip the divider.
// The input side is not ready while a word is in work; a finished result waits in
// the output register while the next input word is taken.
// Reset (aresetn low, synchronous): registers to 28/4/732, layout cleared, row count 1.
module thumbnail_row_placer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [thp_pkg::S_DATA_W-1:0]     s_tdata,   // orig_width, orig_height
    input  wire logic                             s_tuser,   // start_new
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [thp_pkg::M_DATA_W-1:0]     m_tdata,   // pos_x, pos_y, end_x, end_y,
                                                             // scaled_width, rows_used,
                                                             // canvas_height, 2 pad bits
    output logic      [1:0]                       m_tuser,   // status
    // configuration writes
    input  wire logic                             cfg_wen,
    input  wire logic [thp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [thp_pkg::DIM_W-1:0]        cfg_wdata
);
    import thp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,       // ready for an input word
        ST_MUL,        // orig_width * tile height, launch divide
        ST_DIV,        // wait for quotient
        ST_PLACE,      // row break, position, state update
        ST_MUL_ROWS,   // rows * tile height
        ST_MUL_GAPS,   // (rows - 1) * tile gap, sum canvas height
        ST_OUT         // load result register
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] th_reg;
    logic [CFG_W-1:0] ts_reg;
    logic [DIM_W-1:0] cw_reg;

    // layout state
    logic [COL_W-1:0]  col_reg;
    logic [Y_W-1:0]    row_off_reg;
    logic [ROWS_W-1:0] row_cnt_reg;
    logic              err_reg;

    // per-word work registers
    logic [DIM_W-1:0]  ow_reg;
    logic [DIM_W-1:0]  oh_reg;
    logic [QUOT_W-1:0] w_reg;
    logic [QUOT_W-1:0] mul_reg;
    logic [Y_W-1:0]    ch_reg;
    logic [DIM_W-1:0]  px_reg;
    logic [DIM_W-1:0]  ex_reg;
    logic [Y_W-1:0]    py_reg;
    logic [Y_W-1:0]    ey_reg;
    status_t           status_reg;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    status_t             m_status_reg;

    // shared 16x12 multiplier
    logic [DIM_W-1:0]  mul_a;
    logic [CFG_W-1:0]  mul_b;
    logic [QUOT_W-1:0] mul_out;

    always_comb begin
        case (state_reg)
            ST_MUL_ROWS: begin
                mul_a = row_cnt_reg;
                mul_b = th_reg;
            end
            ST_MUL_GAPS: begin
                mul_a = row_cnt_reg - 1'b1;
                mul_b = ts_reg;
            end
            default: begin
                mul_a = ow_reg;
                mul_b = th_reg;
            end
        endcase
    end

    assign mul_out = QUOT_W'(mul_a) * QUOT_W'(mul_b);

    // divider
    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    assign div_start = (state_reg == ST_MUL) && (oh_reg != '0);

    thp_div #(
        .DVD_W (QUOT_W),
        .DVR_W (DIM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_out),
        .divisor  (oh_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // placement arithmetic
    logic [QUOT_W:0]  col_plus_w;
    logic             brk;
    logic             too_wide;
    logic [Y_W:0]     ro_step;
    logic [Y_W-1:0]   ro_new;
    logic [Y_W-1:0]   py_c;
    logic [COL_W-1:0] col_c;
    logic [Y_W:0]     ey_sum;
    logic [Y_W-1:0]   ey_c;
    logic [DIM_W-1:0] ex_c;
    logic [COL_W-1:0] col_upd;
    logic [QUOT_W:0]  ch_sum;

    always_comb begin
        col_plus_w = (QUOT_W+1)'(col_reg) + {1'b0, w_reg};
        brk        = col_plus_w > (QUOT_W+1)'(cw_reg);
        too_wide   = w_reg > QUOT_W'(cw_reg);
        ro_step    = {1'b0, row_off_reg} + (Y_W+1)'(th_reg) + (Y_W+1)'(ts_reg);
        ro_new     = (ro_step > (Y_W+1)'(Y_MAX)) ? Y_MAX : ro_step[Y_W-1:0];
        py_c       = brk ? ro_new : row_off_reg;
        col_c      = brk ? '0 : col_reg;
        ey_sum     = {1'b0, py_c} + (Y_W+1)'(th_reg);
        ey_c       = (ey_sum > (Y_W+1)'(Y_MAX)) ? Y_MAX : ey_sum[Y_W-1:0];
        ex_c       = col_c[DIM_W-1:0] + w_reg[DIM_W-1:0];
        // w fits 16 bits on the placed path
        col_upd    = col_c + w_reg[COL_W-1:0] + COL_W'(ts_reg);
        // never exceeds 29 bits, no saturation needed
        ch_sum     = {1'b0, mul_reg} + {1'b0, mul_out};
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_reg <= TILE_HEIGHT_RST;
            ts_reg <= TILE_GAP_RST;
            cw_reg <= CANVAS_WIDTH_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_TILE_HEIGHT:  th_reg <= cfg_wdata[CFG_W-1:0];
                CFG_TILE_GAP:     ts_reg <= cfg_wdata[CFG_W-1:0];
                CFG_CANVAS_WIDTH: cw_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, layout state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_off_reg  <= '0;
            row_cnt_reg  <= ROWS_W'(1);
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // ST_OUT handles its own drain and reload
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ow_reg    <= s_tdata[DIM_W-1:0];
                        oh_reg    <= s_tdata[2*DIM_W-1:DIM_W];
                        state_reg <= ST_MUL;
                        if (s_tuser) begin
                            col_reg     <= '0;
                            row_off_reg <= '0;
                            row_cnt_reg <= ROWS_W'(1);
                            err_reg     <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    if (oh_reg == '0) begin
                        w_reg     <= '0;
                        state_reg <= ST_PLACE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        w_reg     <= div_quot;
                        state_reg <= ST_PLACE;
                    end
                end
                ST_PLACE: begin
                    state_reg <= ST_MUL_ROWS;
                    if (err_reg) begin
                        status_reg <= STAT_EARLIER_ERR;
                    end else if (oh_reg == '0) begin
                        status_reg <= STAT_ZERO_HEIGHT;
                        err_reg    <= 1'b1;
                    end else if (too_wide) begin
                        status_reg <= STAT_TOO_WIDE;
                        err_reg    <= 1'b1;
                    end else begin
                        status_reg <= STAT_PLACED;
                        px_reg     <= col_c[DIM_W-1:0];
                        py_reg     <= py_c;
                        ex_reg     <= ex_c;
                        ey_reg     <= ey_c;
                        col_reg    <= col_upd;
                        if (brk) begin
                            row_off_reg <= ro_new;
                            if (row_cnt_reg != ROWS_MAX) begin
                                row_cnt_reg <= row_cnt_reg + 1'b1;
                            end
                        end
                    end
                    // no placement on any error path
                    if (err_reg || (oh_reg == '0) || too_wide) begin
                        px_reg <= '0;
                        py_reg <= '0;
                        ex_reg <= '0;
                        ey_reg <= '0;
                    end
                end
                ST_MUL_ROWS: begin
                    mul_reg   <= mul_out;
                    state_reg <= ST_MUL_GAPS;
                end
                ST_MUL_GAPS: begin
                    ch_reg    <= Y_W'(ch_sum);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, ch_reg, row_cnt_reg, w_reg,
                                         ey_reg, ex_reg, py_reg, px_reg};
                        m_status_reg <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

    // checks
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MUL)
        else $error("accepted word did not start the sequencer");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished while sequencer not waiting");

    a_rows_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg != '0)
        else $error("row count reached zero");

    a_unplaced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_PLACED) |->
            (m_tdata[15:0] == '0) && (m_tdata[45:16] == '0) &&
            (m_tdata[61:46] == '0) && (m_tdata[91:62] == '0))
        else $error("error result carries a placement");

endmodule
`default_nettype wire

FILE: rtl/thp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module thp_div #(
    parameter int DVD_W = thp_pkg::QUOT_W,
    parameter int DVR_W = thp_pkg::DIM_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVR_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;
    logic [DVD_W-1:0] quo_reg;   // dividend shifts out at the top, quotient in at the bottom

    logic [DVR_W:0]   rem_sh;
    logic [DVR_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, dvr_reg};
    assign ge     = !diff[DVR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVR_W-1:0] : rem_sh[DVR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: test/thumbnail_row_placer_checker.sv
`timescale 1ns / 100ps
// Watches both streams and the register port, predicts each placement and
// compares result words in order.
module thumbnail_row_placer_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [thp_pkg::S_DATA_W-1:0]  s_tdata,   // orig_width, orig_height
    input  wire logic                          s_tuser,   // start_new
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [thp_pkg::M_DATA_W-1:0]  m_tdata,   // pos_x, pos_y, end_x, end_y,
                                                          // scaled_width, rows_used,
                                                          // canvas_height, pad
    input  wire logic [1:0]                    m_tuser,   // status
    input  wire logic                          cfg_wen,
    input  wire logic [thp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [thp_pkg::DIM_W-1:0]     cfg_wdata,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_checked
);
    import thp_pkg::*;

    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + DIM_W;
    localparam int END_X_LSB  = POS_Y_LSB + Y_W;
    localparam int END_Y_LSB  = END_X_LSB + DIM_W;
    localparam int WIDTH_LSB  = END_Y_LSB + Y_W;
    localparam int ROWS_LSB   = WIDTH_LSB + QUOT_W;
    localparam int CANVAS_LSB = ROWS_LSB + ROWS_W;

    typedef struct packed {
        logic [DIM_W-1:0]  pos_x;
        logic [Y_W-1:0]    pos_y;
        logic [DIM_W-1:0]  end_x;
        logic [Y_W-1:0]    end_y;
        logic [QUOT_W-1:0] scaled_width;
        logic [ROWS_W-1:0] rows_used;
        logic [Y_W-1:0]    canvas_height;
        status_t           status;
    } placement_t;

    // register copies
    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  space_reg;
    logic [DIM_W-1:0]  width_reg;

    // layout state
    logic [COL_W-1:0]  column_pos;
    logic [Y_W-1:0]    row_offset;
    logic [ROWS_W-1:0] row_count;
    logic              error_seen;

    placement_t placements_due[$];

    function automatic logic [Y_W-1:0] clip_y(input logic [63:0] v);
        return (v > 64'(Y_MAX)) ? Y_MAX : v[Y_W-1:0];
    endfunction

    // Advances the layout by one image and returns its placement.
    function automatic placement_t place_thumbnail(input logic start,
                                                   input logic [DIM_W-1:0] ow,
                                                   input logic [DIM_W-1:0] oh);
        placement_t r;
        logic [63:0] quot;
        r = '0;
        if (start) begin
            column_pos = '0;
            row_offset = '0;
            row_count  = ROWS_W'(1);
            error_seen = 1'b0;
        end
        if (oh != 0) begin
            quot = (64'(ow) * 64'(height_reg)) / 64'(oh);
            r.scaled_width = quot[QUOT_W-1:0];
        end
        if (error_seen) begin
            r.status = STAT_EARLIER_ERR;
        end else if (oh == 0) begin
            r.status = STAT_ZERO_HEIGHT;
            error_seen = 1'b1;
        end else if (64'(r.scaled_width) > 64'(width_reg)) begin
            r.status = STAT_TOO_WIDE;
            error_seen = 1'b1;
        end else begin
            if (64'(column_pos) + 64'(r.scaled_width) > 64'(width_reg)) begin
                if (row_count != ROWS_MAX) row_count = row_count + 1'b1;
                column_pos = '0;
                row_offset = clip_y(64'(row_offset) + 64'(height_reg) + 64'(space_reg));
            end
            r.pos_x  = column_pos[DIM_W-1:0];
            r.pos_y  = row_offset;
            r.end_x  = column_pos[DIM_W-1:0] + r.scaled_width[DIM_W-1:0];
            r.end_y  = clip_y(64'(row_offset) + 64'(height_reg));
            column_pos = column_pos + r.scaled_width[COL_W-1:0] + COL_W'(space_reg);
            r.status = STAT_PLACED;
        end
        r.rows_used     = row_count;
        r.canvas_height = clip_y(64'(row_count) * 64'(height_reg)
                                 + 64'(row_count - 1) * 64'(space_reg));
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        placement_t want;
        placement_t got;
        if (!aresetn) begin
            height_reg = TILE_HEIGHT_RST;
            space_reg  = TILE_GAP_RST;
            width_reg  = CANVAS_WIDTH_RST;
            column_pos = '0;
            row_offset = '0;
            row_count  = ROWS_W'(1);
            error_seen = 1'b0;
            placements_due.delete();
            fail_count      = 0;
            results_checked = 0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_TILE_HEIGHT:  height_reg = cfg_wdata[CFG_W-1:0];
                    CFG_TILE_GAP:     space_reg  = cfg_wdata[CFG_W-1:0];
                    CFG_CANVAS_WIDTH: width_reg  = cfg_wdata;
                    default: ;
                endcase
            end
            // pop before push: a word leaving now belongs to an older input
            if (m_tvalid && m_tready) begin
                got.pos_x         = m_tdata[POS_X_LSB +: DIM_W];
                got.pos_y         = m_tdata[POS_Y_LSB +: Y_W];
                got.end_x         = m_tdata[END_X_LSB +: DIM_W];
                got.end_y         = m_tdata[END_Y_LSB +: Y_W];
                got.scaled_width  = m_tdata[WIDTH_LSB +: QUOT_W];
                got.rows_used     = m_tdata[ROWS_LSB +: ROWS_W];
                got.canvas_height = m_tdata[CANVAS_LSB +: Y_W];
                got.status        = status_t'(m_tuser);
                if (placements_due.size() == 0) begin
                    $error("result word with no placement pending");
                    fail_count++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
                    check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
                    check_field("end_x", 32'(want.end_x), 32'(got.end_x));
                    check_field("end_y", 32'(want.end_y), 32'(got.end_y));
                    check_field("scaled_width", 32'(want.scaled_width),
                                32'(got.scaled_width));
                    check_field("rows_used", 32'(want.rows_used), 32'(got.rows_used));
                    check_field("canvas_height", 32'(want.canvas_height),
                                32'(got.canvas_height));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
                results_checked++;
            end
            if (s_tvalid && s_tready)
                placements_due.push_back(place_thumbnail(s_tuser,
                                                         s_tdata[DIM_W-1:0],
                                                         s_tdata[2*DIM_W-1:DIM_W]));
        end
        pending = placements_due.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Top: clock, reset, stimulus, register writes and the verdict.
// All checking lives in the checker instance.
module testbench;
    import thp_pkg::*;

    // run ends here whatever happens; a correct run needs far fewer cycles
    localparam int CYCLE_LIMIT  = 300000;
    // drain margin after the last result
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_WORDS  = 60;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;      // orig_width, orig_height
    logic                 s_tuser   = 1'b0;    // start_new
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;             // pos_x, pos_y, end_x, end_y, scaled_width,
                                               // rows_used, canvas_height, pad
    logic [1:0]           m_tuser;             // status
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TILE_HEIGHT;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending;
    int results_checked;

    int          cycle_count    = 0;
    int          words_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // shadow of what was written, used only to shape stimulus
    int unsigned th_cur = 32'(TILE_HEIGHT_RST);
    int unsigned cw_cur = 32'(CANVAS_WIDTH_RST);

    thumbnail_row_placer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    thumbnail_row_placer_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure; one decision per falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // All tasks below are entered and left at a falling edge.

    // Offer one word, with random idle cycles in front, and hold it until taken.
    task automatic send_word(input logic start, input logic [DIM_W-1:0] ow,
                             input logic [DIM_W-1:0] oh);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {oh, ow};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Sender stops until every result is back, then waits out the pipeline.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    // Registers change only with the block idle.
    task automatic configure(input int unsigned th, input int unsigned sp,
                             input int unsigned cw);
        drain();
        write_reg(CFG_TILE_HEIGHT,  DIM_W'(th));
        write_reg(CFG_TILE_GAP,     DIM_W'(sp));
        write_reg(CFG_CANVAS_WIDTH, DIM_W'(cw));
        th_cur = th;
        cw_cur = cw;
    endtask

    // Image whose thumbnail lands somewhere up to a third of the canvas wide,
    // so rows fill over several words instead of erroring out.
    task automatic send_fitting(input logic start);
        logic [DIM_W-1:0] oh;
        logic [63:0]      ow_wide;
        int unsigned      target;
        oh = ($urandom_range(1) == 1) ? DIM_W'($urandom_range(1, 255))
                                      : DIM_W'($urandom_range(1, 65535));
        target = $urandom_range(0, cw_cur / 3);
        if (th_cur == 0)
            ow_wide = 64'($urandom_range(0, 65535));
        else
            ow_wide = (64'(target) * 64'(oh)) / 64'(th_cur);
        send_word(start, (ow_wide > 64'hFFFF) ? 16'hFFFF : ow_wide[DIM_W-1:0], oh);
    endtask

    // Broken word: zero height, raw random dims, or a near-certain overflow.
    task automatic send_noise();
        case ($urandom_range(2))
            0:       send_word(1'($urandom_range(1)), DIM_W'($urandom_range(65535)), '0);
            1:       send_word(1'b0, DIM_W'($urandom_range(65535)),
                               DIM_W'($urandom_range(65535)));
            default: send_word(1'b0, 16'hFFFF, DIM_W'($urandom_range(1, 16)));
        endcase
    endtask

    // One layout: start flag, a run of fitting images, and now and then an
    // error followed by a few words that must report the earlier error.
    task automatic send_layout(input int unsigned len);
        send_fitting(1'b1);
        repeat (len - 1) send_fitting(1'b0);
        if ($urandom_range(99) < 30) begin
            send_noise();
            repeat ($urandom_range(2)) send_fitting(1'b0);
        end
    endtask

    initial begin : stimulus
        int phase_end;
        send_idle_pct  = 16;
        recv_stall_pct = 66;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words at reset registers: height 28, gap 4, canvas 732
        send_word(1'b1, 16'd0, 16'd1);            // zero-width thumbnail
        send_word(1'b0, 16'hFFFF, 16'hFFFF);      // max dims, width 28
        send_word(1'b0, 16'd100, 16'd28);
        send_word(1'b0, 16'd600, 16'd28);         // overflows column, new row
        send_word(1'b0, 16'd19000, 16'd700);      // wider than canvas
        send_word(1'b0, 16'd100, 16'd28);         // earlier error, width still computed
        send_word(1'b0, 16'd5, 16'd0);            // earlier error with zero height
        send_word(1'b1, 16'd5, 16'd0);            // start clears, then zero height
        send_word(1'b1, 16'd732, 16'd28);         // exactly the canvas width
        send_word(1'b0, 16'd0, 16'hFFFF);         // column past edge: new row at width 0
        send_word(1'b0, 16'd1, 16'hFFFF);         // truncates to width 0
        send_word(1'b0, 16'hFFFF, 16'd1);         // huge width
        send_word(1'b1, 16'hAAAA, 16'h5555);
        send_word(1'b0, 16'h5555, 16'hAAAA);
        repeat (4) send_word(1'b0, 16'd300, 16'd28);
        send_word(1'b0, 16'd733, 16'd28);         // one pixel too wide
        send_word(1'b1, 16'h8000, 16'h8000);
        send_word(1'b0, 16'h7FFF, 16'h7FFF);

        // random layouts over register settings, extremes and out-of-range ones
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(28, 4, 732);
                1: configure(4095, 0, 65535);
                2: configure(1, 4095, 1);
                3: configure(0, 7, 0);       // height 0: every width is 0
                4: configure(17, 0, 0);      // canvas 0: only width 0 fits
                default: configure($urandom_range(1, 4095), $urandom_range(0, 4095),
                                   $urandom_range(1, 65535));
            endcase
            // idling: sender light/receiver heavy, then swapped, then none
            if (p < 2) begin
                send_idle_pct  = 16;
                recv_stall_pct = 66;
            end else if (p < 4) begin
                send_idle_pct  = 66;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
                send_layout($urandom_range(3, 12));
        end

        drain();
        $display("sent %0d words, checked %0d results over six register settings",
                 words_sent, results_checked);
        $display("covered row wraps, too-wide, zero-height, sticky errors, zero-size regs");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
